// File: rtl/zero_crossing_interpolator_assert.svh
// ---------------------------------------------------------------------------
// Zero crossing interpolator assertion macros
// Short forms for the concurrent checks used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ZERO_CROSSING_INTERPOLATOR_ASSERT_SVH
`define ZERO_CROSSING_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define ZCI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zci check failed");

// Next-cycle implication, off while reset is high.
`define ZCI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zci check failed");

// Same-cycle implication that also holds across reset.
`define ZCI_ASSERT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("zci check failed");

`endif

// File: rtl/zci_pkg.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator package
// Shared codes and control types of the crossing interpolator.
// ---------------------------------------------------------------------------
package zci_pkg;

  // Crossing direction codes
  localparam logic KIND_RISING  = 1'b0;
  localparam logic KIND_FALLING = 1'b1;

  // Queue status seen by both the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } zci_qstat_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } back_state_t;

endpackage

// File: rtl/zci_if.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator channels
// Sample input channel and crossing result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface sample_if #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic        [TIME_BITS-1:0]   sample_time;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, sample_time, sample_value, input ready);
  modport sink   (input valid, sample_time, sample_value, output ready);
endinterface

interface root_if #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] root_time;
  logic                 root_kind;

  modport source (output valid, root_time, root_kind, input ready);
  modport sink   (input valid, root_time, root_kind, output ready);
endinterface

// File: rtl/zero_crossing_interpolator.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator
// Detects sign changes in timestamped samples and interpolates the crossing.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle while the two-entry job queue has room;
// zero samples and samples of the kept sign give no result. Each sign
// change becomes a job for the back end, which loads it, runs a serial
// multiply-divide loop that takes one dt bit per step, and then adds the
// base time into the output register once that register is free. The back
// end takes no new job until it has handed off the last; the queue lets new
// samples arrive while a result waits or a division is under way.
// ---------------------------------------------------------------------------
module zero_crossing_interpolator #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input logic    clk,
  input logic    rst,
  sample_if.sink samples,
  root_if.source roots
);
  import zci_pkg::*;

  localparam int JOB_W = 2 * TIME_BITS + 2 * SAMPLE_BITS + 2;

  zci_qstat_t       qstat;
  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             pop;
  logic [JOB_W-1:0] pop_data;

  zci_front #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .qstat    (qstat),
    .push     (push),
    .push_data(push_data)
  );

  zci_queue #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .status   (qstat)
  );

  zci_back #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .job_data(pop_data),
    .pop     (pop),
    .roots   (roots)
  );

endmodule

// File: rtl/zci_queue.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator job queue
// Small FIFO that decouples crossing detection from the interpolation.
// ---------------------------------------------------------------------------
module zci_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  pop_data,
  output zci_pkg::zci_qstat_t status
);
  import zci_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = slots[rd_ptr];

  // Store a request at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/zci_front.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator front end
// Keeps the last nonzero sample and queues a job on each sign change.
// ---------------------------------------------------------------------------
module zci_front #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int JOB_W       = 2 * 32 + 2 * 16 + 2
) (
  input  logic                clk,
  input  logic                rst,
  sample_if.sink              samples,
  input  zci_pkg::zci_qstat_t qstat,
  output logic                push,
  output logic [JOB_W-1:0]    push_data
);
  import zci_pkg::*;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS:0]   divisor;
    logic [SAMPLE_BITS-1:0] mag_prev;
    logic [TIME_BITS-1:0]   dt;
    logic [TIME_BITS-1:0]   base;
  } job_t;

  logic [TIME_BITS-1:0]   last_time;
  logic [SAMPLE_BITS-1:0] last_value;
  logic                   have_last;

  logic                   accept;
  logic                   nonzero;
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS-1:0] mag_prev;
  logic [SAMPLE_BITS-1:0] mag_cur;
  job_t                   job;

  assign samples.ready = !qstat.full;
  assign accept        = samples.valid && samples.ready;
  assign cur           = samples.sample_value;
  assign nonzero       = (cur != '0);

  // Magnitudes as unsigned; the most negative value maps to 2^(SAMPLE_BITS-1)
  assign mag_prev = last_value[SAMPLE_BITS-1] ? (~last_value + 1'b1) : last_value;
  assign mag_cur  = cur[SAMPLE_BITS-1] ? (~cur + 1'b1) : cur;

  // Build the interpolation request
  always_comb begin
    job.kind     = last_value[SAMPLE_BITS-1] ? KIND_RISING : KIND_FALLING;
    job.divisor  = {1'b0, mag_prev} + {1'b0, mag_cur};
    job.mag_prev = mag_prev;
    job.dt       = samples.sample_time - last_time;
    job.base     = last_time;
  end

  assign push      = accept && nonzero && have_last &&
                     (cur[SAMPLE_BITS-1] != last_value[SAMPLE_BITS-1]);
  assign push_data = job;

  // Keep the latest nonzero sample; drop zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      last_value <= '0;
      have_last  <= 1'b0;
    end else if (accept && nonzero) begin
      last_time  <= samples.sample_time;
      last_value <= cur;
      have_last  <= 1'b1;
    end
  end

endmodule

// File: rtl/zci_back.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator back end
// Bit-serial multiply-divide of dt * |prev| / (|prev| + |cur|), then offset.
// ---------------------------------------------------------------------------
module zci_back #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int JOB_W       = 2 * 32 + 2 * 16 + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  zci_pkg::zci_qstat_t qstat,
  input  logic [JOB_W-1:0]    job_data,
  output logic                pop,
  root_if.source              roots
);
  import zci_pkg::*;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS:0]   divisor;
    logic [SAMPLE_BITS-1:0] mag_prev;
    logic [TIME_BITS-1:0]   dt;
    logic [TIME_BITS-1:0]   base;
  } job_t;

  localparam int RW    = SAMPLE_BITS + 2;
  localparam int CNT_W = $clog2(TIME_BITS + 1);

  job_t                   job;
  back_state_t            state;
  back_state_t            state_next;
  logic [TIME_BITS-1:0]   base;
  logic [TIME_BITS-1:0]   dt;
  logic [SAMPLE_BITS-1:0] mag_prev;
  logic [SAMPLE_BITS:0]   divisor;
  logic                   kind;
  logic [TIME_BITS-1:0]   quot;
  logic [SAMPLE_BITS:0]   rem;
  logic [CNT_W-1:0]       cnt;

  logic                   out_valid;
  logic [TIME_BITS-1:0]   out_time;
  logic                   out_kind;

  logic [RW-1:0]          t0;
  logic [RW-1:0]          t1;
  logic [RW-1:0]          t2;
  logic [RW-1:0]          dext;
  logic                   k0;
  logic                   k1;
  logic [TIME_BITS-1:0]   quot_step;
  logic                   hold_fire;

  assign job       = job_data;
  assign pop       = (state == ST_IDLE) && !qstat.empty;
  assign hold_fire = (state == ST_HOLD) && (!out_valid || roots.ready);

  // One dt bit per cycle: rem = 2*rem + bit*|prev|, then take out up to two divisors
  always_comb begin
    dext      = RW'(divisor);
    t0        = {rem, 1'b0} + (dt[TIME_BITS-1] ? RW'(mag_prev) : '0);
    k0        = (t0 >= dext);
    t1        = k0 ? (t0 - dext) : t0;
    k1        = (t1 >= dext);
    t2        = k1 ? (t1 - dext) : t1;
    quot_step = {quot[TIME_BITS-2:0], 1'b0} + TIME_BITS'({k0 && k1, k0 ^ k1});
  end

  // Sequence load, iterate, hand off
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (hold_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      base     <= job.base;
      dt       <= job.dt;
      mag_prev <= job.mag_prev;
      divisor  <= job.divisor;
      kind     <= job.kind;
      quot     <= '0;
      rem      <= '0;
      cnt      <= CNT_W'(TIME_BITS);
    end else if (state == ST_RUN) begin
      dt   <= {dt[TIME_BITS-2:0], 1'b0};
      quot <= quot_step;
      rem  <= t2[SAMPLE_BITS:0];
      cnt  <= cnt - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_fire) begin
      out_valid <= 1'b1;
    end else if (roots.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire) begin
      out_time <= base + quot;
      out_kind <= kind;
    end
  end

  assign roots.valid     = out_valid;
  assign roots.root_time = out_time;
  assign roots.root_kind = out_kind;

endmodule

// File: rtl/zci_checker.sv
// ---------------------------------------------------------------------------
// Zero crossing interpolator checker
// Port-level checks on the result channel and reset behavior.
// ---------------------------------------------------------------------------
`include "zero_crossing_interpolator_assert.svh"

module zci_checker #(
  parameter int TIME_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [TIME_BITS-1:0] out_time,
  input logic                 out_kind
);

  // Hold a stalled result
  `ZCI_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ZCI_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable({out_time, out_kind}))

  // Reset drops any pending result and empties the queue
  `ZCI_ASSERT_ALL(a_rst_out, clk, $past(rst), !out_valid)
  `ZCI_ASSERT_ALL(a_rst_ready, clk, $past(rst), in_ready)

endmodule

bind zero_crossing_interpolator zci_checker #(
  .TIME_BITS(TIME_BITS)
) u_zci_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (samples.ready),
  .out_valid(roots.valid),
  .out_ready(roots.ready),
  .out_time (roots.root_time),
  .out_kind (roots.root_kind)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Zero crossing interpolator testbench
// Sends timestamped samples and checks each crossing result, in order,
// against a local predictor. Both sides idle at random. One long
// receiver hold-off makes the block fill up and stall its sample input.
// ---------------------------------------------------------------------------
module tb;
  import zci_pkg::*;

  localparam int TIME_BITS   = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;

  typedef logic        [TIME_BITS-1:0]   time_word_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_word_t;

  typedef struct packed {
    time_word_t root_time;
    logic       root_kind;
  } crossing_t;

  // Crossing predictor and store of pending crossings
  class crossing_scoreboard;
    crossing_t    pending_roots[$];
    time_word_t   kept_time;
    sample_word_t kept_value;
    bit           have_kept;

    function new();
      kept_time  = '0;
      kept_value = '0;
      have_kept  = 1'b0;
    endfunction

    function int pending();
      return pending_roots.size();
    endfunction

    // Predict the crossing, if any, caused by one accepted sample
    function void note_sample(time_word_t t, sample_word_t v);
      logic [SAMPLE_BITS:0] ext_kept;
      logic [SAMPLE_BITS:0] ext_cur;
      logic [SAMPLE_BITS:0] mag_kept;
      logic [SAMPLE_BITS:0] mag_cur;
      time_word_t           dt;
      logic [63:0]          prod;
      logic [63:0]          quot;
      crossing_t            root;
      if (v == '0) return;
      if (have_kept && (v[SAMPLE_BITS-1] != kept_value[SAMPLE_BITS-1])) begin
        ext_kept = {kept_value[SAMPLE_BITS-1], kept_value};
        ext_cur  = {v[SAMPLE_BITS-1], v};
        mag_kept = kept_value[SAMPLE_BITS-1] ? (~ext_kept + 1'b1) : ext_kept;
        mag_cur  = v[SAMPLE_BITS-1] ? (~ext_cur + 1'b1) : ext_cur;
        dt       = t - kept_time;
        prod     = 64'(dt) * 64'(mag_kept);
        quot     = prod / (64'(mag_kept) + 64'(mag_cur));
        root.root_time = kept_time + quot[TIME_BITS-1:0];
        root.root_kind = kept_value[SAMPLE_BITS-1] ? KIND_RISING : KIND_FALLING;
        pending_roots.push_back(root);
      end
      kept_time  = t;
      kept_value = v;
      have_kept  = 1'b1;
    endfunction

    // Compare one result with the oldest pending crossing
    function bit check_root(time_word_t t, logic k, output string msg);
      crossing_t want;
      msg = "";
      if (pending_roots.size() == 0) begin
        msg = $sformatf("unexpected root time=%0d kind=%0d", t, k);
        return 1'b0;
      end
      want = pending_roots.pop_front();
      if (t !== want.root_time)
        msg = $sformatf("root_time got %0d want %0d;", t, want.root_time);
      if (k !== want.root_kind)
        msg = {msg, $sformatf(" root_kind got %0d want %0d", k, want.root_kind)};
      return (msg == "");
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sample_if #(.TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  root_if   #(.TIME_BITS(TIME_BITS))                            root_ch ();

  zero_crossing_interpolator #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch),
    .roots  (root_ch)
  );

  crossing_scoreboard sb;
  int         error_count   = 0;
  int         cycle_count   = 0;
  bit         tx_idle_en    = 1'b1;
  bit         rx_idle_en    = 1'b1;
  int         rx_hold_req   = 0;
  bit         reset_done    = 1'b0;
  time_word_t cur_time      = '0;
  bit         last_neg      = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drive every input from time zero
  initial begin
    rst                    = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_time  = '0;
    sample_ch.sample_value = '0;
    root_ch.ready          = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[zero_crossing_interpolator] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offer one sample request and hold it until accepted
  task automatic send_sample(input time_word_t t, input sample_word_t v);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_time  <= t;
    sample_ch.sample_value <= v;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    sb.note_sample(t, v);
  endtask

  // Nonzero value of the given sign, weighted toward small and extreme sizes
  function automatic sample_word_t signed_value(input bit neg);
    logic [SAMPLE_BITS:0] mag;
    int                   sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) mag = 17'($urandom_range(1, 64));
    else if (sel < 8) mag = 17'($urandom_range(1, 32767));
    else if (sel == 8) mag = neg ? 17'd32768 : 17'd32767;
    else mag = 17'd1;
    return neg ? sample_word_t'(~mag + 1'b1) : sample_word_t'(mag);
  endfunction

  // Mostly sign flips, with zero runs, same-sign samples and raw noise
  function automatic sample_word_t pick_value();
    sample_word_t v;
    int           sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) v = signed_value(!last_neg);
    else if (sel < 75) v = '0;
    else if (sel < 90) v = signed_value(last_neg);
    else v = sample_word_t'($urandom);
    if (v != '0) last_neg = v[SAMPLE_BITS-1];
    return v;
  endfunction

  // Mostly small forward steps; sometimes big jumps or time going back
  function automatic time_word_t pick_time();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 90) cur_time = cur_time + time_word_t'($urandom_range(0, 2000));
    else if (sel < 95) cur_time = cur_time + time_word_t'($urandom);
    else cur_time = time_word_t'($urandom);
    return cur_time;
  endfunction

  task automatic run_random(input int n_items);
    time_word_t t;
    sample_word_t v;
    repeat (n_items) begin
      t = pick_time();
      v = pick_value();
      send_sample(t, v);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, check each root
  initial begin : root_receiver
    int    gap;
    string msg;
    wait (reset_done);
    forever begin
      if (rx_hold_req > 0) begin
        root_ch.ready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        root_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      root_ch.ready <= 1'b1;
      do @(posedge clk); while (!(root_ch.valid && root_ch.ready));
      if (!sb.check_root(root_ch.root_time, root_ch.root_kind, msg))
        report_mismatch(msg);
    end
  end

  // Main sequence
  initial begin : sample_sender
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reset_done = 1'b1;

    // Directed: first sample, zero runs, extremes, wrap and backward time
    send_sample(32'd0, 16'sd0);
    send_sample(32'd10, 16'sd100);
    send_sample(32'd20, 16'sd0);
    send_sample(32'd30, 16'sd0);
    send_sample(32'd40, -16'sd100);
    send_sample(32'd50, -16'sd5);
    send_sample(32'd60, 16'sd32767);
    send_sample(32'd1000, -16'sd32768);
    send_sample(32'hFFFF_FFFF, 16'sd32767);
    send_sample(32'hFFFF_FFFF, -16'sd1);
    send_sample(32'd5, 16'sd1);
    send_sample(32'd3, -16'sd32768);
    send_sample(32'h8000_0000, 16'sd32767);
    send_sample(32'h8000_0000, 16'sd0);
    send_sample(32'hFFFF_FFFF, -16'sd32768);
    send_sample(32'h0000_0000, 16'sd1);
    send_sample(32'h5555_5555, -16'sd1);
    send_sample(32'hAAAA_AAAA, 16'sd32767);
    send_sample(32'hAAAA_AAAA, 16'sd12345);
    send_sample(32'hFFFF_FFFE, -16'sd21846);
    cur_time = 32'hFFFF_FFFE;
    last_neg = 1'b1;

    // Random phases with different idling on each side
    tx_idle_en = 1'b1; rx_idle_en = 1'b1;
    run_random(460);
    tx_idle_en = 1'b0; rx_idle_en = 1'b0;
    run_random(460);

    // Long receiver hold-off while crossings keep coming
    rx_hold_req = HOLD_CYCLES;
    tx_idle_en  = 1'b0;
    repeat (60) begin
      last_neg = !last_neg;
      send_sample(pick_time(), signed_value(last_neg));
    end
    rx_hold_req = 0;

    tx_idle_en = 1'b1; rx_idle_en = 1'b0;
    run_random(460);
    tx_idle_en = 1'b0; rx_idle_en = 1'b1;
    run_random(460);

    sample_ch.valid <= 1'b0;

    // Drain, then let any stray result show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      report_mismatch($sformatf("%0d crossings never arrived", sb.pending()));

    if (error_count == 0) begin
      $display("[zero_crossing_interpolator] OK");
    end else begin
      $display("[zero_crossing_interpolator] ERROR");
    end
    $finish;
  end
endmodule
